// ===== hdl/grid_bfs_tile_enumerator_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef GRID_BFS_TILE_ENUMERATOR_UNIT_ASSERT_SVH
`define GRID_BFS_TILE_ENUMERATOR_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GBT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define GBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/gbt_pkg.sv =====
`default_nettype none
package gbt_pkg;
	localparam int CoordW = 6;
	localparam int DistW = 13;
	localparam int DimW = 7;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_RCLEAR,
		ST_IDLE,
		ST_POP,
		ST_NBR,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_START_NE = 3'd0,
		REG_START_SE = 3'd1,
		REG_MAP_WIDTH = 3'd2,
		REG_MAP_HEIGHT = 3'd3,
		REG_RADIUS_SQ = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic clear_start;
		logic clear_step;
		logic restart;
		logic pop_read;
		logic pop_take;
		logic nbr_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic need_restart;
		logic nbr_last;
	} status_t;
endpackage
`default_nettype wire

// ===== hdl/gbt_if.sv =====
`default_nettype none
interface gbt_in_if;
	logic valid;
	logic ready;
	logic force_restart;
	modport source(output valid, output force_restart, input ready);
	modport sink(input valid, input force_restart, output ready);
endinterface

interface gbt_out_if;
	logic valid;
	logic ready;
	logic [5:0] tile_ne;
	logic [5:0] tile_se;
	logic restarted;
	modport source(output valid, output tile_ne, output tile_se, output restarted, input ready);
	modport sink(input valid, input tile_ne, input tile_se, input restarted, output ready);
endinterface
`default_nettype wire

// ===== hdl/gbt_ctrl.sv =====
`default_nettype none
module gbt_ctrl import gbt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_force,
	output logic in_ready,
	input wire logic out_busy,
	input wire status_t status,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_done) state_d = ST_IDLE;
			end
			// Sweep for a restart; the start tile is then popped at once.
			ST_RCLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_done) state_d = ST_POP;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_force || status.need_restart) begin
						cmd.clear_start = 1'b1;
						cmd.restart = 1'b1;
						state_d = ST_RCLEAR;
					end else begin
						cmd.pop_read = 1'b1;
						state_d = ST_POP;
					end
				end
			end
			ST_POP: begin
				cmd.pop_take = 1'b1;
				state_d = ST_NBR;
			end
			ST_NBR: begin
				cmd.nbr_step = 1'b1;
				if (status.nbr_last) state_d = ST_OUT;
			end
			// Wait here while the result register still holds an untaken beat.
			ST_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/gbt_datapath.sv =====
`default_nettype none
module gbt_datapath import gbt_pkg::*; #(
	parameter int MAP_DIM = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output status_t status,
	input wire logic [CoordW-1:0] start_ne,
	input wire logic [CoordW-1:0] start_se,
	input wire logic [DimW-1:0] map_width,
	input wire logic [DimW-1:0] map_height,
	input wire logic [DistW-1:0] radius_sq,
	output logic out_valid,
	input wire logic out_ready,
	output logic [CoordW-1:0] tile_ne,
	output logic [CoordW-1:0] tile_se,
	output logic restarted
);
	localparam int CW = $clog2(MAP_DIM);
	localparam int AW = 2 * CW;
	localparam int Cells = 1 << AW;
	localparam int NW = AW + 1;
	localparam int XW = (CW + 2 > DimW + 1) ? CW + 2 : DimW + 1;
	localparam int LW = DistW + CW + 1;

	logic [AW-1:0] fifo_mem [Cells];
	logic vis_mem [Cells];
	logic [AW-1:0] head_q, clr_q;
	logic [NW-1:0] count_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cur_ne_q, cur_se_q;
	logic [1:0] nbr_q;
	logic vis_rd_q;
	logic phase_q;
	logic pend_restart_q;
	logic [LW-1:0] last_q;

	// saturated start and map bounds
	logic [CW-1:0] sne, sse;
	logic [XW-1:0] wlim, hlim;
	always_comb begin
		sne = (start_ne > CoordW'(MAP_DIM - 1)) ? CW'(MAP_DIM - 1) : CW'(start_ne);
		sse = (start_se > CoordW'(MAP_DIM - 1)) ? CW'(MAP_DIM - 1) : CW'(start_se);
		wlim = (XW'(map_width) > XW'(MAP_DIM)) ? XW'(MAP_DIM) : XW'(map_width);
		hlim = (XW'(map_height) > XW'(MAP_DIM)) ? XW'(MAP_DIM) : XW'(map_height);
	end

	// candidate neighbour in order ne+1, se+1, ne-1, se-1
	logic signed [XW-1:0] cne, cse;
	logic in_map;
	logic [AW-1:0] cidx;
	always_comb begin
		cne = $signed(XW'(cur_ne_q));
		cse = $signed(XW'(cur_se_q));
		case (nbr_q)
			2'd0: cne = cne + XW'(1);
			2'd1: cse = cse + XW'(1);
			2'd2: cne = cne - XW'(1);
			default: cse = cse - XW'(1);
		endcase
		in_map = (cne >= 0) && (cse >= 0) && (cne < $signed(wlim)) && (cse < $signed(hlim));
		cidx = {cse[CW-1:0], cne[CW-1:0]};
	end

	logic [AW-1:0] sidx;
	assign sidx = {sse, sne};

	// neighbour step: phase 0 reads visited, phase 1 writes
	logic do_push;
	assign do_push = cmd.nbr_step && phase_q && in_map && !vis_rd_q;
	assign status.nbr_last = phase_q && (nbr_q == 2'd3);
	assign status.clear_done = clr_q == AW'(Cells - 1);

	always_ff @(posedge clk) begin
		if (cmd.clear_step) vis_mem[clr_q] <= (clr_q == sidx) && pend_restart_q;
		else if (do_push) vis_mem[cidx] <= 1'b1;
		if (cmd.nbr_step && !phase_q) vis_rd_q <= vis_mem[cidx];
		if (cmd.clear_step && status.clear_done && pend_restart_q) fifo_mem[0] <= sidx;
		else if (do_push) fifo_mem[head_q + AW'(count_q)] <= cidx;
		if (cmd.clear_step && status.clear_done && pend_restart_q) rd_q <= sidx;
		else if (cmd.pop_read) rd_q <= fifo_mem[head_q];
	end

	logic signed [CW+1:0] dne, dse;
	logic [LW-1:0] dist_sq;
	always_comb begin
		dne = $signed({2'b00, cur_ne_q}) - $signed({2'b00, sne});
		dse = $signed({2'b00, cur_se_q}) - $signed({2'b00, sse});
		dist_sq = LW'(dne * dne) + LW'(dse * dse);
	end

	assign status.need_restart = (count_q == '0) ||
		((radius_sq != '0) && (last_q > LW'(radius_sq)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			head_q <= '0;
			count_q <= '0;
			nbr_q <= '0;
			phase_q <= 1'b0;
			pend_restart_q <= 1'b0;
			last_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clear_start) begin
				clr_q <= '0;
				pend_restart_q <= 1'b1;
			end else if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
				if (status.clear_done) begin
					clr_q <= '0;
					if (pend_restart_q) begin
						head_q <= '0;
						count_q <= NW'(1);
					end
				end
			end
			if (cmd.pop_take) begin
				head_q <= head_q + AW'(1);
				count_q <= count_q - NW'(1);
				cur_ne_q <= rd_q[CW-1:0];
				cur_se_q <= rd_q[AW-1:CW];
				nbr_q <= '0;
				phase_q <= 1'b0;
			end
			if (cmd.nbr_step) begin
				phase_q <= !phase_q;
				if (phase_q) nbr_q <= nbr_q + 2'd1;
				if (do_push) count_q <= count_q + NW'(1);
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
				restarted <= pend_restart_q;
				tile_ne <= CoordW'(cur_ne_q);
				tile_se <= CoordW'(cur_se_q);
				last_q <= dist_sq;
				pend_restart_q <= 1'b0;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/gbt_regs.sv =====
`default_nettype none
module gbt_regs import gbt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic [CoordW-1:0] start_ne,
	output logic [CoordW-1:0] start_se,
	output logic [DimW-1:0] map_width,
	output logic [DimW-1:0] map_height,
	output logic [DistW-1:0] radius_sq
);
	logic wr;
	logic [2:0] idx;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_ne <= '0;
			start_se <= '0;
			map_width <= DimW'(64);
			map_height <= DimW'(64);
			radius_sq <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_START_NE: start_ne <= pwdata[CoordW-1:0];
				REG_START_SE: start_se <= pwdata[CoordW-1:0];
				REG_MAP_WIDTH: map_width <= pwdata[DimW-1:0];
				REG_MAP_HEIGHT: map_height <= pwdata[DimW-1:0];
				REG_RADIUS_SQ: radius_sq <= pwdata[DistW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_START_NE: prdata = 32'(start_ne);
			REG_START_SE: prdata = 32'(start_se);
			REG_MAP_WIDTH: prdata = 32'(map_width);
			REG_MAP_HEIGHT: prdata = 32'(map_height);
			REG_RADIUS_SQ: prdata = 32'(radius_sq);
			default: prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/grid_bfs_tile_enumerator_unit.sv =====
// Steps: a step without restart runs from the accepted beat to its result beat through
// pop read, pop, four neighbour read/write pairs and output load, in that order.
// A restarting step first sweeps the visited bitmap (4096 entries at MAP_DIM 64) and loads the
// start tile in place of the pop read, then runs the pop, the neighbour pairs and the output load.
// A new beat is taken only in idle, after the last result is loaded; a waiting result beat stalls only the output load.
// Reset: asynchronous active low; the bitmap is then swept clear before the first beat is taken.
`default_nettype none
module grid_bfs_tile_enumerator_unit import gbt_pkg::*; #(
	parameter int MAP_DIM = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	gbt_in_if.sink in_ch,
	gbt_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [CoordW-1:0] start_ne, start_se;
	logic [DimW-1:0] map_width, map_height;
	logic [DistW-1:0] radius_sq;
	cmd_t cmd;
	status_t status;
	logic out_valid;

	assign pready = 1'b1;
	assign out_ch.valid = out_valid;

	// Register file: written in the APB access phase.
	gbt_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.start_ne, .start_se, .map_width, .map_height, .radius_sq
	);

	// The controller sequences the bitmap sweep, the pop and the neighbour visits.
	// The result register is busy only while it holds a beat that is not taken this cycle.
	gbt_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid),
		.in_force(in_ch.force_restart),
		.in_ready(in_ch.ready),
		.out_busy(out_valid && !out_ch.ready),
		.status, .cmd
	);

	// The datapath holds the frontier FIFO, the visited bitmap and the result register.
	gbt_datapath #(.MAP_DIM(MAP_DIM)) u_dp (
		.clk, .arst_n, .cmd, .status,
		.start_ne, .start_se, .map_width, .map_height, .radius_sq,
		.out_valid, .out_ready(out_ch.ready),
		.tile_ne(out_ch.tile_ne), .tile_se(out_ch.tile_se), .restarted(out_ch.restarted)
	);
endmodule
`default_nettype wire

// ===== hdl/gbt_checker.sv =====
`default_nettype none
`include "grid_bfs_tile_enumerator_unit_assert.svh"
module gbt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic pready
);
	`GBT_ASSERT_NEXT(a_one_beat_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	`GBT_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid)
	`GBT_ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind grid_bfs_tile_enumerator_unit gbt_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.pready(pready)
);
`default_nettype wire

// ===== verif/gbt_tb_if.sv =====
`default_nettype none
// Testbench-side channel instances reuse the RTL interfaces; this file holds the
// stall/gap pattern helper shared by driver and monitor.
package gbt_tb_pkg;
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(8, 40);
		end
	endfunction
endpackage
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
	import gbt_pkg::*;
	import gbt_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Dim = 64;
	localparam int Cells = Dim * Dim;
	// A restart costs a full bitmap sweep plus a step; allow for that on every item.
	localparam longint CycleLimit = 64'd12_000_000;

	typedef struct packed {
		logic [5:0] tile_ne;
		logic [5:0] tile_se;
		logic restarted;
	} tile_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	gbt_in_if in_ch();
	gbt_out_if out_ch();

	grid_bfs_tile_enumerator_unit #(.MAP_DIM(Dim)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow of the walk: configuration, frontier FIFO and visited bitmap.
	logic [5:0] cfg_start_ne;
	logic [5:0] cfg_start_se;
	logic [6:0] cfg_width;
	logic [6:0] cfg_height;
	logic [12:0] cfg_radius_sq;
	logic [11:0] frontier[Cells];
	int unsigned frontier_head;
	int unsigned frontier_count;
	bit seen[Cells];
	int unsigned prev_dist_sq;

	logic pending_restart[$];
	tile_beat_t expected_tiles[$];
	int unsigned errors = 0;
	int unsigned mismatches = 0;
	bit stimulus_done = 1'b0;
	longint cycles = 0;

	function automatic int unsigned clamp_dim(int unsigned v);
		return (v > Dim - 1) ? Dim - 1 : v;
	endfunction

	function automatic void enqueue_tile(int unsigned idx);
		if (frontier_count < Cells) begin
			frontier[(frontier_head + frontier_count) % Cells] = idx[11:0];
			frontier_count++;
		end
	endfunction

	function automatic void visit_neighbor(int ne, int se);
		int unsigned w;
		int unsigned h;
		int unsigned idx;
		w = (cfg_width > Dim) ? Dim : cfg_width;
		h = (cfg_height > Dim) ? Dim : cfg_height;
		if (ne < 0 || se < 0 || ne >= int'(w) || se >= int'(h)) begin
			return;
		end
		idx = se * Dim + ne;
		if (!seen[idx]) begin
			seen[idx] = 1'b1;
			enqueue_tile(idx);
		end
	endfunction

	// Advances the shadow walk by one request and returns the tile it must yield.
	function automatic tile_beat_t next_bfs_tile(logic force_req);
		tile_beat_t t;
		logic restart;
		int unsigned idx;
		int ne;
		int se;
		int dne;
		int dse;
		restart = force_req;
		if (frontier_count == 0) begin
			restart = 1'b1;
		end
		if (cfg_radius_sq != 0 && prev_dist_sq > cfg_radius_sq) begin
			restart = 1'b1;
		end
		if (restart) begin
			idx = clamp_dim(cfg_start_se) * Dim + clamp_dim(cfg_start_ne);
			foreach (seen[i]) seen[i] = 1'b0;
			frontier_head = 0;
			frontier_count = 0;
			enqueue_tile(idx);
			seen[idx] = 1'b1;
		end
		idx = frontier[frontier_head];
		frontier_head = (frontier_head + 1) % Cells;
		frontier_count--;
		ne = idx % Dim;
		se = idx / Dim;
		visit_neighbor(ne + 1, se);
		visit_neighbor(ne, se + 1);
		visit_neighbor(ne - 1, se);
		visit_neighbor(ne, se - 1);
		dne = ne - int'(clamp_dim(cfg_start_ne));
		dse = se - int'(clamp_dim(cfg_start_se));
		prev_dist_sq = dne * dne + dse * dse;
		t.tile_ne = ne[5:0];
		t.tile_se = se[5:0];
		t.restarted = restart;
		return t;
	endfunction

	// Driver: one beat per pending request, with random gaps between beats.
	int unsigned send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.force_restart <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_tiles.push_back(next_bfs_tile(in_ch.force_restart));
				void'(pending_restart.pop_front());
				send_gap = pick_gap();
			end
			if (in_ch.valid && !in_ch.ready) begin
				// Hold the beat until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				in_ch.valid <= 1'b0;
				in_ch.force_restart <= 1'($urandom_range(0, 1));
			end else if (pending_restart.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.force_restart <= pending_restart[0];
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: random backpressure, each result beat checked against the oldest expectation.
	int unsigned stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		tile_beat_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_tiles.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected tile beat ne=%0d se=%0d restarted=%0b",
							out_ch.tile_ne, out_ch.tile_se, out_ch.restarted);
					end
				end else begin
					want = expected_tiles.pop_front();
					if (out_ch.tile_ne !== want.tile_ne || out_ch.tile_se !== want.tile_se
							|| out_ch.restarted !== want.restarted) begin
						errors++;
						mismatches++;
						if (mismatches <= 10) begin
							$display("tile mismatch: expected ne=%0d se=%0d restarted=%0b, got ne=%0d se=%0d restarted=%0b",
								want.tile_ne, want.tile_se, want.restarted,
								out_ch.tile_ne, out_ch.tile_se, out_ch.restarted);
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				out_ch.ready <= (stall_left == 0);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("grid_bfs_tile_enumerator_unit regression: fail");
			$finish;
		end
	end

	// APB write: setup cycle then access cycle; the shadow copy follows the register.
	task automatic write_reg(reg_idx_t which, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * int'(which));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (which)
			REG_START_NE: cfg_start_ne = value[5:0];
			REG_START_SE: cfg_start_se = value[5:0];
			REG_MAP_WIDTH: cfg_width = value[6:0];
			REG_MAP_HEIGHT: cfg_height = value[6:0];
			REG_RADIUS_SQ: cfg_radius_sq = value[12:0];
			default: ;
		endcase
	endtask

	task automatic set_walk(int sne, int sse, int w, int h, int rsq);
		write_reg(REG_START_NE, sne);
		write_reg(REG_START_SE, sse);
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
		write_reg(REG_RADIUS_SQ, rsq);
	endtask

	// Every request yields a tile, so idle means all requests sent and all tiles back.
	task automatic wait_drained();
		while (pending_restart.size() > 0 || expected_tiles.size() > 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	// Mostly plain steps so walks reach deep; occasional forced restarts.
	task automatic queue_requests(int n, int force_pct);
		repeat (n) pending_restart.push_back($urandom_range(0, 99) < force_pct);
	endtask

	initial begin
		cfg_start_ne = 0;
		cfg_start_se = 0;
		cfg_width = 7'd64;
		cfg_height = 7'd64;
		cfg_radius_sq = 0;
		frontier_head = 0;
		frontier_count = 0;
		prev_dist_sq = 0;
		foreach (seen[i]) seen[i] = 1'b0;
		foreach (frontier[i]) frontier[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset defaults, corner start, then a forced restart.
		queue_requests(6, 0);
		pending_restart.push_back(1'b1);
		pending_restart.push_back(1'b0);
		wait_drained();
		// Tiny 2x2 map exhausts the FIFO and restarts on empty.
		set_walk(1, 1, 2, 2, 0);
		queue_requests(6, 0);
		wait_drained();
		// Start outside the map, zero-sized and oversized map, saturating radius.
		set_walk(63, 63, 0, 127, 1);
		queue_requests(3, 0);
		wait_drained();
		set_walk(40, 20, 127, 0, 7938);
		queue_requests(3, 0);
		wait_drained();
		set_walk(63, 0, 64, 64, 8191);
		queue_requests(3, 0);
		wait_drained();

		// Random phases, mostly small maps to keep walks short.
		for (int ph = 0; ph < 17; ph++) begin
			int w;
			int h;
			w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
			set_walk($urandom_range(0, 63), $urandom_range(0, 63), w, h,
				($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8191));
			queue_requests(50, 4);
			wait_drained();
		end
		stimulus_done = 1'b1;

		if (errors == 0) begin
			$display("grid_bfs_tile_enumerator_unit regression: pass");
		end else begin
			$display("grid_bfs_tile_enumerator_unit regression: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
